>>> rtl/bssm_pkg.sv
// Shared definitions for the byte stream signature matcher.
// Holds the signature dictionary, register indexes and verdict codes.
// No dependencies.
`default_nettype none

package bssm_pkg;

  localparam int SIG_COUNT   = 19;
  localparam int SIG_MAX_LEN = 27;
  localparam int SIG_TEXT_W  = SIG_MAX_LEN * 8;
  localparam int THR_W       = 5;
  localparam int CNT_W       = 3;
  localparam int CFG_INDEX_W = 1;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_POSITIVE_THR   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SUSPICIOUS_THR = 1'd1;

  localparam logic [THR_W-1:0] POSITIVE_THR_RESET   = 5'd3;
  localparam logic [THR_W-1:0] SUSPICIOUS_THR_RESET = 5'd1;

  localparam logic [1:0] VERDICT_NEGATIVE   = 2'd0;
  localparam logic [1:0] VERDICT_SUSPICIOUS = 2'd1;
  localparam logic [1:0] VERDICT_POSITIVE   = 2'd2;

  // A string literal is right aligned in the vector: byte 0 holds the last
  // character of the signature, byte k the character k places before it.
  localparam logic [SIG_TEXT_W-1:0] SIG_TEXT [SIG_COUNT] = '{
    "IsDebuggerPresent",
    "CheckRemoteDebuggerPresent",
    "ZwQueryInformationProcess",
    "NtQueryInformationProcess",
    "SetUnhandledExceptionFilter",
    "UnhandledExceptionFilter",
    "IsBadReadPtr",
    "IsBadWritePtr",
    "IsBadCodePtr",
    "GetTickCount",
    "QueryPerformanceCounter",
    "timeGetTime",
    "GetSystemTime",
    "GetLocalTime",
    "rdtsc",
    "OutputDebugStringA",
    "OutputDebugStringW",
    "DbgPrint",
    "DbgPrompt"
  };

  localparam int SIG_LEN [SIG_COUNT] = '{
    17, 26, 25, 25, 27, 24, 12, 13, 12, 12, 23, 11, 13, 12, 5, 18, 18, 8, 9
  };

  // Handoff of a finished file from the scanner to the report stage.
  typedef struct packed {
    logic                 fire;
    logic [SIG_COUNT-1:0] found;
  } bssm_req_t;

endpackage

`default_nettype wire

>>> rtl/bssm_scan.sv
// Input register, byte history and parallel signature comparators.
// Depends on bssm_pkg for the dictionary and the handoff struct.
// Passes the seen flags of a finished file to bssm_report.
`default_nettype none

module bssm_scan
  import bssm_pkg::*;
#(
  parameter int HIST_DEPTH = SIG_MAX_LEN - 1
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic       end_of_file,
  input  wire logic       slot_free,
  output bssm_req_t       req
);

  logic                 hold_valid;
  logic [7:0]           hold_byte;
  logic                 hold_last;
  logic [7:0]           history [HIST_DEPTH];
  logic [SIG_COUNT-1:0] seen;
  logic [SIG_COUNT-1:0] seen_next;
  logic [SIG_COUNT-1:0] hit;
  logic [7:0]           win [SIG_MAX_LEN];
  logic                 advance;
  logic                 take;

  // A plain byte always moves on; the last byte of a file needs the slot.
  assign advance  = hold_valid && (!hold_last || slot_free);
  assign in_ready = !hold_valid || advance;
  assign take     = in_valid && in_ready;

  assign win[0] = hold_byte;
  for (genvar k = 1; k < SIG_MAX_LEN; k++) begin : g_win
    assign win[k] = history[k-1];
  end

  for (genvar s = 0; s < SIG_COUNT; s++) begin : g_sig
    logic [SIG_MAX_LEN-1:0] byte_ok;
    for (genvar k = 0; k < SIG_MAX_LEN; k++) begin : g_byte
      if (k < SIG_LEN[s]) begin : g_cmp
        assign byte_ok[k] = (win[k] == SIG_TEXT[s][8*k +: 8]);
      end else begin : g_pad
        assign byte_ok[k] = 1'b1;
      end
    end
    assign hit[s] = &byte_ok;
  end

  assign seen_next = seen | hit;

  assign req.fire  = advance && hold_last;
  assign req.found = seen_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (take) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold_byte <= data_byte;
      hold_last <= end_of_file;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        history[i] <= '0;
      end
    end else if (advance) begin
      if (hold_last) begin
        seen <= '0;
        for (int i = 0; i < HIST_DEPTH; i++) begin
          history[i] <= '0;
        end
      end else begin
        seen       <= seen_next;
        history[0] <= hold_byte;
        for (int i = 1; i < HIST_DEPTH; i++) begin
          history[i] <= history[i-1];
        end
      end
    end
  end

  // The last item of a file waits in the input register until the slot frees.
  a_last_holds: assert property (@(posedge clk) disable iff (rst)
    (hold_valid && hold_last && !slot_free) |=> (hold_valid && hold_last))
    else $error("last item left the input register while the slot was busy");

  // Finishing a file starts the next one with no flags set.
  a_flags_cleared: assert property (@(posedge clk) disable iff (rst)
    req.fire |=> (seen == '0))
    else $error("seen flags not cleared after end of file");

  // Flags only ever grow within a file.
  a_flags_sticky: assert property (@(posedge clk) disable iff (rst)
    (advance && !hold_last) |=> ((seen & $past(seen)) == $past(seen)))
    else $error("a seen flag was lost within a file");

endmodule

`default_nettype wire

>>> rtl/bssm_report.sv
// Per-group counts, verdict and the result register.
// Depends on bssm_pkg; takes finished files from bssm_scan.
`default_nettype none

module bssm_report
  import bssm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [THR_W-1:0]       cfg_data,
  input  wire bssm_req_t              req,
  output logic                        slot_free,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [SIG_COUNT-1:0]        found_mask,
  output logic [CNT_W-1:0]            direct_hits,
  output logic [CNT_W-1:0]            exception_hits,
  output logic [CNT_W-1:0]            timing_hits,
  output logic [CNT_W-1:0]            debug_string_hits,
  output logic [THR_W-1:0]            total_hits,
  output logic [1:0]                  verdict
);

  logic [THR_W-1:0] positive_thr;
  logic [THR_W-1:0] suspicious_thr;
  logic [CNT_W-1:0] direct_next;
  logic [CNT_W-1:0] exception_next;
  logic [CNT_W-1:0] timing_next;
  logic [CNT_W-1:0] debug_next;
  logic [THR_W-1:0] total_next;
  logic [1:0]       verdict_next;

  assign slot_free = !out_valid || out_ready;

  // Groups: direct bits 0..3, exception 4..8, timing 9..14, debug string 15..18.
  assign direct_next    = CNT_W'($countones(req.found[3:0]));
  assign exception_next = CNT_W'($countones(req.found[8:4]));
  assign timing_next    = CNT_W'($countones(req.found[14:9]));
  assign debug_next     = CNT_W'($countones(req.found[18:15]));
  assign total_next     = THR_W'(direct_next) + THR_W'(exception_next)
                        + THR_W'(timing_next) + THR_W'(debug_next);

  always_comb begin
    priority if (total_next >= positive_thr) begin
      verdict_next = VERDICT_POSITIVE;
    end else if (total_next >= suspicious_thr) begin
      verdict_next = VERDICT_SUSPICIOUS;
    end else begin
      verdict_next = VERDICT_NEGATIVE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      positive_thr   <= POSITIVE_THR_RESET;
      suspicious_thr <= SUSPICIOUS_THR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POSITIVE_THR:   positive_thr   <= cfg_data;
        REG_SUSPICIOUS_THR: suspicious_thr <= cfg_data;
        default:            positive_thr   <= positive_thr;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (req.fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.fire) begin
      found_mask        <= req.found;
      direct_hits       <= direct_next;
      exception_hits    <= exception_next;
      timing_hits       <= timing_next;
      debug_string_hits <= debug_next;
      total_hits        <= total_next;
      verdict           <= verdict_next;
    end
  end

  // The total always agrees with the group counts it was built from.
  a_total_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (total_hits == THR_W'(direct_hits) + THR_W'(exception_hits)
                               + THR_W'(timing_hits) + THR_W'(debug_string_hits)))
    else $error("total does not match the group counts");

  // The group counts agree with the found mask.
  a_mask_counts: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (THR_W'($countones(found_mask)) == total_hits))
    else $error("found mask and total disagree");

endmodule

`default_nettype wire

>>> rtl/byte_stream_signature_matcher.sv
// Top level of the byte stream signature matcher.
// Depends on bssm_pkg, bssm_scan and bssm_report.
//
// Usage: the bytes of one file enter on the input channel (in_valid,
// in_ready, data_byte, end_of_file), one item per cycle. Every item is
// compared in parallel against all 19 signatures using the current byte and
// the history of earlier bytes; a match sets a sticky seen flag. The item
// with end_of_file set produces exactly one result item on the output
// channel (out_valid, out_ready and the result fields); no other item
// produces one. After that item the history and flags are cleared, so the
// next byte starts a fresh file.
// The last item passes through the input register and the result register.
// Throughput: one item per cycle, set by the single input register in
// front of the comparators. A result waiting in the output register does
// not block ordinary bytes; only a following end-of-file item waits in
// the input register until that result is taken, so input stalls follow
// output stalls by at most one file.
// Reset clears the history, the flags, both valid bits and loads the thresholds
// with 3 (positive) and 1 (suspicious). Thresholds are written by the user via
// cfg_we/cfg_index/cfg_data while no file is in flight; not enforced here.
`default_nettype none

module byte_stream_signature_matcher
  import bssm_pkg::*;
#(
  parameter int MAX_SIGNATURE_LEN = SIG_MAX_LEN
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [THR_W-1:0]       cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [7:0]             data_byte,
  input  wire logic                   end_of_file,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [SIG_COUNT-1:0]        found_mask,
  output logic [CNT_W-1:0]            direct_hits,
  output logic [CNT_W-1:0]            exception_hits,
  output logic [CNT_W-1:0]            timing_hits,
  output logic [CNT_W-1:0]            debug_string_hits,
  output logic [THR_W-1:0]            total_hits,
  output logic [1:0]                  verdict
);

  // The history holds every byte but the current one of the longest signature.
  bssm_req_t req;
  logic      slot_free;

  bssm_scan #(
    .HIST_DEPTH(MAX_SIGNATURE_LEN - 1)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .end_of_file(end_of_file),
    .slot_free  (slot_free),
    .req        (req)
  );

  // Counts, verdict and the result register that decouples the receiver.
  bssm_report u_report (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .req              (req),
    .slot_free        (slot_free),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .found_mask       (found_mask),
    .direct_hits      (direct_hits),
    .exception_hits   (exception_hits),
    .timing_hits      (timing_hits),
    .debug_string_hits(debug_string_hits),
    .total_hits       (total_hits),
    .verdict          (verdict)
  );

endmodule

`default_nettype wire
